### hw/rtl/lruc_pkg.sv
// Shared constants and types of the LRU cache hit counter.
`default_nettype none
package lruc_pkg;

    localparam int WAYS       = 16;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int CAP_W      = 5;
    localparam int TGT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OCC_W      = $clog2(WAYS + 1);
    localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int GOAL_W     = (COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HITS = 1'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET    = CAP_W'(16);
    localparam logic [TGT_W-1:0] TARGET_HITS_RESET = '0;

    typedef struct packed {
        logic accept;
        logic found;
        logic active;
        logic in_range;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/lruc_stream_if.sv
// Valid/ready stream interfaces for access and result transactions.
`default_nettype none
interface lruc_access_if;
    logic                           valid;
    logic                           ready;
    logic [lruc_pkg::KEY_BITS-1:0]  key;
    logic                           last_of_run;

    modport source (output valid, output key, output last_of_run, input ready);
    modport sink   (input valid, input key, input last_of_run, output ready);
endinterface

interface lruc_result_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [lruc_pkg::COUNT_BITS-1:0]  hit_count;
    logic                             goal_met;
    logic                             run_end;

    modport source (output valid, output hit, output hit_count, output goal_met,
                    output run_end, input ready);
    modport sink   (input valid, input hit, input hit_count, input goal_met,
                    input run_end, output ready);
endinterface
`default_nettype wire

### hw/rtl/lru_cache_hit_counter_core.sv
// Top level of the LRU cache hit counter: recency cell chain, counters, output register.
// Fully associative LRU cache of WAYS keys built as a chain of cells, entry 0 most recent.
// For each access transaction, all cells compare the key in parallel and
// the chain shifts one step in the same edge, so a new access is accepted every cycle and
// its result appears in the output register on the next cycle. Access stalls only while a
// result waits in the output register and the result side is not ready. A transaction with
// last_of_run set clears the occupancy and hit counter after its result is formed.
`default_nettype none
module lru_cache_hit_counter_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    lruc_access_if.sink                                access,
    lruc_result_if.source                              result,
    input  wire logic                                  cfg_we,
    input  wire logic [lruc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [lruc_pkg::CFG_W-1:0]            cfg_data
);

    logic [lruc_pkg::CAP_W-1:0]       capacity_reg;
    logic [lruc_pkg::TGT_W-1:0]       target_hits_reg;
    logic [lruc_pkg::OCC_W-1:0]       occupancy_reg;
    logic [lruc_pkg::OCC_W-1:0]       occupancy_next;
    logic [lruc_pkg::COUNT_BITS-1:0]  hit_total_reg;
    logic [lruc_pkg::COUNT_BITS-1:0]  hit_total_next;

    logic                             out_valid_reg;
    logic                             out_hit_reg;
    logic [lruc_pkg::COUNT_BITS-1:0]  out_count_reg;
    logic                             out_goal_reg;
    logic                             out_end_reg;

    logic [lruc_pkg::CMP_W-1:0]       cap_wide;
    logic [lruc_pkg::OCC_W-1:0]       cap;
    logic [lruc_pkg::OCC_W-1:0]       occ_eff;
    logic [lruc_pkg::OCC_W-1:0]       new_occ;
    logic                             accept;
    logic                             found;
    logic                             goal;

    logic [lruc_pkg::WAYS:0]          match_chain;
    logic [lruc_pkg::KEY_BITS-1:0]    key_chain [lruc_pkg::WAYS+1];
    lruc_pkg::cell_ctrl_t             ctrl [lruc_pkg::WAYS];

    assign access.ready = !out_valid_reg || result.ready;
    assign accept       = access.valid && access.ready;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_wide = lruc_pkg::CMP_W'(1);
        end
        else if (lruc_pkg::CMP_W'(capacity_reg) > lruc_pkg::CMP_W'(lruc_pkg::WAYS))
        begin
            cap_wide = lruc_pkg::CMP_W'(lruc_pkg::WAYS);
        end
        else
        begin
            cap_wide = lruc_pkg::CMP_W'(capacity_reg);
        end
    end

    assign cap     = cap_wide[lruc_pkg::OCC_W-1:0];
    assign occ_eff = (occupancy_reg > cap) ? cap : occupancy_reg;
    assign found   = match_chain[lruc_pkg::WAYS];
    assign new_occ = (!found && (occ_eff < cap)) ? occ_eff + lruc_pkg::OCC_W'(1) : occ_eff;

    assign match_chain[0] = 1'b0;
    assign key_chain[0]   = access.key;

    genvar gi;
    generate
        for (gi = 0; gi < lruc_pkg::WAYS; gi++)
        begin : g_cell
            assign ctrl[gi].accept   = accept;
            assign ctrl[gi].found    = found;
            assign ctrl[gi].active   = lruc_pkg::OCC_W'(gi) < occ_eff;
            assign ctrl[gi].in_range = lruc_pkg::OCC_W'(gi) < new_occ;

            lruc_cell u_cell (
                .clk        (clk),
                .lookup_key (access.key),
                .prev_key   (key_chain[gi]),
                .ctrl       (ctrl[gi]),
                .match_in   (match_chain[gi]),
                .match_out  (match_chain[gi+1]),
                .key_out    (key_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (found && (hit_total_reg != '1))
        begin
            hit_total_next = hit_total_reg + lruc_pkg::COUNT_BITS'(1);
        end
        else
        begin
            hit_total_next = hit_total_reg;
        end
        occupancy_next = access.last_of_run ? '0 : new_occ;
    end

    assign goal = lruc_pkg::GOAL_W'(hit_total_next) >= lruc_pkg::GOAL_W'(target_hits_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= lruc_pkg::CAPACITY_RESET;
            target_hits_reg <= lruc_pkg::TARGET_HITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lruc_pkg::CFG_CAPACITY:    capacity_reg    <= cfg_data[lruc_pkg::CAP_W-1:0];
                lruc_pkg::CFG_TARGET_HITS: target_hits_reg <= cfg_data[lruc_pkg::TGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            hit_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occupancy_reg <= occupancy_next;
                hit_total_reg <= access.last_of_run ? '0 : hit_total_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_hit_reg   <= found;
            out_count_reg <= hit_total_next;
            out_goal_reg  <= goal;
            out_end_reg   <= access.last_of_run;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.hit       = out_hit_reg;
    assign result.hit_count = out_count_reg;
    assign result.goal_met  = out_goal_reg;
    assign result.run_end   = out_end_reg;

endmodule
`default_nettype wire

### hw/rtl/lruc_cell.sv
// One recency cell: holds a key, compares it and shifts from its neighbor.
`default_nettype none
module lruc_cell (
    input  wire logic                           clk,
    input  wire logic [lruc_pkg::KEY_BITS-1:0]  lookup_key,
    input  wire logic [lruc_pkg::KEY_BITS-1:0]  prev_key,
    input  wire lruc_pkg::cell_ctrl_t           ctrl,
    input  wire logic                           match_in,
    output logic                                match_out,
    output logic [lruc_pkg::KEY_BITS-1:0]       key_out
);

    logic [lruc_pkg::KEY_BITS-1:0] key_reg;
    logic                          hit_here;
    logic                          shift;

    assign hit_here  = ctrl.active && (key_reg == lookup_key);
    assign match_out = match_in || hit_here;
    assign shift     = ctrl.accept && !match_in && (ctrl.found || ctrl.in_range);
    assign key_out   = key_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= prev_key;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lruc_checker.sv
// Port-level assertions for the LRU cache hit counter and their bind.
`default_nettype none
module lruc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                access_valid,
    input wire logic                                access_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic                                result_hit,
    input wire logic [lruc_pkg::COUNT_BITS-1:0]     result_hit_count
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_hit_count))
        else $error("hit_count changed while stalled");

    a_access_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && access_ready |=> result_valid)
        else $error("accepted transaction produced no result");

    a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !access_ready |-> result_valid && !result_ready)
        else $error("access stalled without a pending result");

    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_hit |-> result_hit_count != '0)
        else $error("hit reported with zero hit_count");

endmodule

bind lru_cache_hit_counter_core lruc_checker u_lruc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .access_valid     (access.valid),
    .access_ready     (access.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_hit       (result.hit),
    .result_hit_count (result.hit_count)
);
`default_nettype wire
